[hw/rtl/wsfe_pkg.sv]
// shared types, constants and header helpers for the websocket frame encoder
// no dependencies; imported by the front end, queue, back end and top level
package wsfe_pkg;

   localparam int CMD_DEPTH_DEF = 4;
   localparam int LEN_W         = 63;
   localparam int KEY_W         = 32;
   localparam int BYTE_W        = 8;
   localparam int HDR_IDX_W     = 4;
   localparam int HDR_MAX_BYTES = 14;

   localparam logic [7:0] FIN_BIT   = 8'h80;
   localparam logic [7:0] MASK_BIT  = 8'h80;
   localparam logic [6:0] MID_CODE  = 7'd126;
   localparam logic [6:0] LONG_CODE = 7'd127;
   localparam logic [LEN_W-1:0] SHORT_MAX = LEN_W'(125);
   localparam logic [LEN_W-1:0] MID_MAX   = LEN_W'(16'hFFFF);

   typedef enum logic [1:0] {
      FMT_SHORT,
      FMT_MID,
      FMT_LONG
   } fmt_type;

   typedef enum logic {
      CMD_HDR,
      CMD_DATA
   } cmd_kind_type;

   // one queued command from front to back
   typedef struct packed {
      cmd_kind_type     kind;
      fmt_type          fmt;
      logic             empty_frame;
      logic [3:0]       opcode;
      logic [LEN_W-1:0] len;
      logic [KEY_W-1:0] key;
      logic [7:0]       data;
      logic             frame_end;
      logic             out_of_frame;
   } cmd_type;

   function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                           input logic [1:0] phase);
      logic [7:0] b;
      unique case (phase)
         2'd0: b = key[31:24];
         2'd1: b = key[23:16];
         2'd2: b = key[15:8];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [HDR_IDX_W-1:0] hdr_last_idx(input fmt_type fmt);
      logic [HDR_IDX_W-1:0] r;
      unique case (fmt)
         FMT_SHORT: r = HDR_IDX_W'(5);
         FMT_MID:   r = HDR_IDX_W'(7);
         FMT_LONG:  r = HDR_IDX_W'(13);
         default:   r = HDR_IDX_W'(13);
      endcase
      return r;
   endfunction

   // header byte at position idx, first byte on the wire is position 0
   function automatic logic [7:0] hdr_byte(input cmd_type c,
                                           input logic [HDR_IDX_W-1:0] idx);
      logic [8*HDR_MAX_BYTES-1:0] hdr;
      logic [7:0]                 b0;
      b0 = FIN_BIT | {4'd0, c.opcode};
      unique case (c.fmt)
         FMT_SHORT: hdr = {b0, MASK_BIT | {1'b0, c.len[6:0]}, c.key, 64'd0};
         FMT_MID:   hdr = {b0, MASK_BIT | {1'b0, MID_CODE}, c.len[15:0], c.key, 48'd0};
         FMT_LONG:  hdr = {b0, MASK_BIT | {1'b0, LONG_CODE}, 1'b0, c.len, c.key};
         default:   hdr = {b0, MASK_BIT | {1'b0, LONG_CODE}, 1'b0, c.len, c.key};
      endcase
      return hdr[8*(HDR_MAX_BYTES-1-int'(idx)) +: 8];
   endfunction

endpackage

[hw/rtl/wsfe_front.sv]
// front end: takes request words, keeps frame state, masks payload bytes
// depends on wsfe_pkg; feeds wsfe_cmd_fifo
module wsfe_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_func,
   input  logic [3:0]                    req_opcode,
   input  logic [wsfe_pkg::LEN_W-1:0]    req_frame_length,
   input  logic [wsfe_pkg::KEY_W-1:0]    req_frame_mask,
   input  logic [wsfe_pkg::BYTE_W-1:0]   req_payload_byte,
   output wsfe_pkg::cmd_type             cmd
);
   import wsfe_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [1:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic             open_ff, open_in;
   logic             last_byte;

   assign last_byte = (left_ff == LEN_W'(1));

   always_comb begin
      key_in   = key_ff;
      phase_in = phase_ff;
      left_in  = left_ff;
      open_in  = open_ff;

      cmd              = '0;
      cmd.opcode       = req_opcode;
      cmd.len          = req_frame_length;
      cmd.key          = req_frame_mask;
      cmd.empty_frame  = (req_frame_length == '0);
      if (req_frame_length <= SHORT_MAX) begin
         cmd.fmt = FMT_SHORT;
      end else if (req_frame_length <= MID_MAX) begin
         cmd.fmt = FMT_MID;
      end else begin
         cmd.fmt = FMT_LONG;
      end

      if (!req_func) begin
         cmd.kind = CMD_HDR;
         if (accept) begin
            key_in   = req_frame_mask;
            phase_in = 2'd0;
            left_in  = req_frame_length;
            open_in  = (req_frame_length != '0);
         end
      end else if (!open_ff) begin
         // stray payload byte: flagged and dropped
         cmd.kind         = CMD_DATA;
         cmd.out_of_frame = 1'b1;
      end else begin
         cmd.kind      = CMD_DATA;
         cmd.data      = req_payload_byte ^ key_byte(key_ff, phase_ff);
         cmd.frame_end = last_byte;
         if (accept) begin
            phase_in = phase_ff + 2'd1;
            left_in  = left_ff - LEN_W'(1);
            if (last_byte) begin
               open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         phase_ff <= '0;
         left_ff  <= '0;
         open_ff  <= 1'b0;
      end else begin
         key_ff   <= key_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
         open_ff  <= open_in;
      end
   end

endmodule

[hw/rtl/wsfe_cmd_fifo.sv]
// short command queue between front end and header sequencer
// depends on wsfe_pkg for the command type
module wsfe_cmd_fifo #(
   parameter int DEPTH = wsfe_pkg::CMD_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  wsfe_pkg::cmd_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output wsfe_pkg::cmd_type rd_data,
   output logic              not_empty
);
   import wsfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;
   assign rd_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/wsfe_back.sv]
// back end: walks header bytes one per cycle while no result waits unpopped
// and drives the result register; depends on wsfe_pkg, reads wsfe_cmd_fifo
module wsfe_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  wsfe_pkg::cmd_type            cmd,
   output logic                         cmd_pop,
   input  logic                         pop,
   output logic                         empty,
   output logic [wsfe_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_run_last,
   output logic                         rsp_frame_end,
   output logic                         rsp_out_of_frame
);
   import wsfe_pkg::*;

   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 fend_ff, fend_in;
   logic                 oof_ff, oof_in;
   logic                 adv, hdr_last;

   assign adv      = !valid_ff || pop;
   assign hdr_last = (idx_ff == hdr_last_idx(cmd.fmt));

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !pop;
      byte_in  = byte_ff;
      last_in  = last_ff;
      fend_in  = fend_ff;
      oof_in   = oof_ff;
      cmd_pop  = 1'b0;
      if (adv && cmd_valid) begin
         valid_in = 1'b1;
         unique case (cmd.kind)
            CMD_DATA: begin
               byte_in = cmd.data;
               last_in = 1'b1;
               fend_in = cmd.frame_end;
               oof_in  = cmd.out_of_frame;
               cmd_pop = 1'b1;
            end
            default: begin
               byte_in = hdr_byte(cmd, idx_ff);
               last_in = hdr_last;
               fend_in = hdr_last && cmd.empty_frame;
               oof_in  = 1'b0;
               if (hdr_last) begin
                  cmd_pop = 1'b1;
                  idx_in  = '0;
               end else begin
                  idx_in = idx_ff + HDR_IDX_W'(1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      fend_ff <= fend_in;
      oof_ff  <= oof_in;
   end

   assign empty            = !valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_out_of_frame = oof_ff;

endmodule

[hw/rtl/websocket_frame_encoder.sv]
// top level of the client-side websocket frame encoder
// depends on wsfe_pkg, wsfe_front, wsfe_cmd_fifo and wsfe_back
//
// Client-side websocket frame encoder. A start word (req_func 0) opens a frame and
// yields its header as a run of result words: the opcode byte with fin set, the
// length byte with the mask bit (7-bit length, or 126 and a 16-bit big-endian
// length, or 127 and a 64-bit big-endian length), then the four key bytes, first
// key byte from bits 31..24. That is 6, 8 or 14 result words. A payload word
// (req_func 1) yields one word, the byte xor-ed with the next key byte, and
// rsp_frame_end marks the byte that completes the frame (an empty frame marks its
// last key byte). A payload word with no frame open yields one word with
// rsp_out_of_frame set and byte 0; the payload byte is dropped. A start while a
// frame is open abandons it. Timing: a request word is taken whenever the
// command queue (CMD_DEPTH entries) has room; the result side delivers one
// word per cycle while pop keeps the result register free, so payload words
// stream at one per cycle and a start word holds the header sequencer for its
// 6, 8 or 14 header words. A taken word goes to the queue, then from its head
// into a single output register on the rsp_ ports, where results wait.
module websocket_frame_encoder #(
   parameter int CMD_DEPTH = wsfe_pkg::CMD_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         push,
   output logic                         full,
   input  logic                         req_func,
   input  logic [3:0]                   req_opcode,
   input  logic [wsfe_pkg::LEN_W-1:0]   req_frame_length,
   input  logic [wsfe_pkg::KEY_W-1:0]   req_frame_mask,
   input  logic [wsfe_pkg::BYTE_W-1:0]  req_payload_byte,
   // result side
   output logic                         empty,
   input  logic                         pop,
   output logic [wsfe_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_run_last,
   output logic                         rsp_frame_end,
   output logic                         rsp_out_of_frame
);
   import wsfe_pkg::*;

   // command passed from the front end into the queue
   cmd_type front_cmd;
   // command at the head of the queue
   cmd_type head_cmd;
   logic    accept;
   logic    head_valid;
   logic    head_pop;

   // a word is taken whenever the queue has room
   assign accept = push && !full;

   // frame state and payload masking
   wsfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_func         (req_func),
      .req_opcode       (req_opcode),
      .req_frame_length (req_frame_length),
      .req_frame_mask   (req_frame_mask),
      .req_payload_byte (req_payload_byte),
      .cmd              (front_cmd)
   );

   // decouples request acceptance from header expansion
   wsfe_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (push),
      .wr_data   (front_cmd),
      .full      (full),
      .rd_en     (head_pop),
      .rd_data   (head_cmd),
      .not_empty (head_valid)
   );

   // header sequencer and result register
   wsfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (head_valid),
      .cmd              (head_cmd),
      .cmd_pop          (head_pop),
      .pop              (pop),
      .empty            (empty),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_out_of_frame (rsp_out_of_frame)
   );

endmodule

[hw/rtl/wsfe_checker.sv]
// port-level checks for websocket_frame_encoder, attached by bind
// depends only on the top level's ports
module wsfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_frame_end,
   input logic       rsp_out_of_frame
);

   // nothing waits on either side right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not clear after reset");

   // a stray payload word is a single zero word that never ends a frame
   a_oof_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_out_of_frame) |->
         (rsp_run_last && !rsp_frame_end && (rsp_out_byte == 8'd0)))
      else $error("bad out-of-frame word");

   // a frame can only end on the last word of a run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_end) |-> rsp_run_last)
      else $error("frame end not on last word of run");

   // a waiting result's byte, run-last and frame-end flags hold until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=>
         (!empty && $stable(rsp_out_byte) && $stable(rsp_run_last)
          && $stable(rsp_frame_end)))
      else $error("result changed while stalled");

endmodule

bind websocket_frame_encoder wsfe_checker u_wsfe_checker (
   .clock            (clock),
   .reset            (reset),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_run_last     (rsp_run_last),
   .rsp_frame_end    (rsp_frame_end),
   .rsp_out_of_frame (rsp_out_of_frame)
);
